[hw/rtl/dtgd_pkg.sv]
// Shared types and constants of the double-tap gesture detector.
// Depends on nothing; every other file of the block imports it.
package dtgd_pkg;

    localparam int TIME_BITS_DEFAULT   = 17;
    localparam int QUEUE_DEPTH_DEFAULT = 2;
    localparam int TERM_W              = 16;
    localparam logic [TERM_W-1:0] TERM_RESET = 16'd200;

    typedef enum logic [1:0] {
        CMD_KEY_EDGE  = 2'd0,
        CMD_OTHER_KEY = 2'd1,
        CMD_TICK      = 2'd2,
        CMD_SESS_RST  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_PASS    = 3'd0,
        KIND_SWALLOW = 3'd1,
        KIND_PRESS   = 3'd2,
        KIND_RELEASE = 3'd3,
        KIND_TOGGLE  = 3'd4
    } kind_t;

    typedef enum logic [4:0] {
        PH_IDLE        = 5'b00001,
        PH_FIRST_DOWN  = 5'b00010,
        PH_WAIT_SECOND = 5'b00100,
        PH_SECOND_DOWN = 5'b01000,
        PH_PASS_HELD   = 5'b10000
    } phase_t;

    // One queued group of results: count beats taken from kind0 upward.
    typedef struct packed {
        logic [1:0] count;
        kind_t      kind0;
        kind_t      kind1;
        kind_t      kind2;
    } entry_t;

endpackage

[hw/rtl/double_tap_gesture_detector.sv]
// Top level of the double-tap gesture detector.
// Depends on dtgd_pkg, dtgd_front, dtgd_queue and dtgd_back.
//
// Watches one special key and turns a quick release-then-press into a
// manual-mode toggle. Each input beat is a special key edge (with the
// session-alive flag), another key event, a millisecond tick or a session
// reset. A first press is swallowed; a second press within the term followed
// by its release gives a toggle; a timeout, other key event or session reset
// replays the held press or the whole tap as press/release results; a held
// key then passes through until released. Each input beat yields zero to three
// result beats, the last one flagged by m_last. The front end takes one input
// beat per cycle while the result queue (QUEUE_DEPTH groups) has room, and a
// beat with no results never enters the queue. The back end drives one
// result beat per cycle while m_ready is high, as many beats as the group
// has results. An accepted group is written into the queue, and the back
// end then loads it into its own register before it drives the first
// result beat. The term register is written through cfg_we/cfg_wdata;
// the user must write it only while idle, as the block itself does not
// enforce this. It resets to 200 ms.
module double_tap_gesture_detector #(
    parameter int TIME_BITS   = dtgd_pkg::TIME_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = dtgd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [dtgd_pkg::TERM_W-1:0] cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_command,
    input  logic                        s_pressed,
    input  logic                        s_session_alive,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [2:0]                  m_result_kind,
    output logic                        m_last
);
    import dtgd_pkg::*;

    logic [TERM_W-1:0] term_reg;
    logic              push, pop, q_not_empty, q_not_full;
    entry_t            push_entry, pop_entry;

    // Hold the double-tap term; write it only while the block is idle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_reg <= TERM_RESET;
        end else if (cfg_we) begin
            term_reg <= cfg_wdata;
        end
    end

    // Accept a new beat whenever the queue can take a result group.
    assign s_ready = q_not_full;

    dtgd_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_valid),
        .in_ready         (s_ready),
        .in_command       (s_command),
        .in_pressed       (s_pressed),
        .in_session_alive (s_session_alive),
        .term             (term_reg),
        .push             (push),
        .push_entry       (push_entry)
    );

    dtgd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .not_empty  (q_not_empty),
        .not_full   (q_not_full)
    );

    dtgd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_entry     (pop_entry),
        .q_pop       (pop),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_kind    (m_result_kind),
        .out_last    (m_last)
    );

endmodule

[hw/rtl/dtgd_front.sv]
// Front end: accepts input beats, runs the gesture state machine and tick timer,
// and classifies each beat into a group of results. Depends on dtgd_pkg.
module dtgd_front #(
    parameter int TIME_BITS = dtgd_pkg::TIME_BITS_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [1:0]                  in_command,
    input  logic                        in_pressed,
    input  logic                        in_session_alive,
    input  logic [dtgd_pkg::TERM_W-1:0] term,
    output logic                        push,
    output dtgd_pkg::entry_t            push_entry
);
    import dtgd_pkg::*;

    localparam int CMP_W = (TIME_BITS > TERM_W) ? TIME_BITS : TERM_W;

    phase_t               phase_reg, phase_next;
    logic [TIME_BITS-1:0] time_reg, time_next, time_inc;
    logic [CMP_W-1:0]     time_cmp, inc_cmp, term_cmp;
    entry_t               ent;
    logic                 accept;

    assign accept   = in_valid && in_ready;
    assign time_inc = (time_reg == {TIME_BITS{1'b1}}) ? time_reg : time_reg + 1'b1;
    assign time_cmp = CMP_W'(time_reg);
    assign inc_cmp  = CMP_W'(time_inc);
    assign term_cmp = CMP_W'(term);

    always_comb begin
        phase_next = phase_reg;
        time_next  = time_reg;
        ent.count  = 2'd0;
        ent.kind0  = KIND_PASS;
        ent.kind1  = KIND_PASS;
        ent.kind2  = KIND_PASS;
        case (cmd_t'(in_command))
            CMD_KEY_EDGE: begin
                ent.count = 2'd1;
                if (phase_reg == PH_PASS_HELD) begin
                    if (!in_pressed) phase_next = PH_IDLE;
                end else if (!in_session_alive) begin
                    ent.kind0 = KIND_PASS;
                end else begin
                    case (phase_reg)
                        PH_IDLE: begin
                            if (in_pressed) begin
                                phase_next = PH_FIRST_DOWN;
                                time_next  = '0;
                                ent.kind0  = KIND_SWALLOW;
                            end
                        end
                        PH_FIRST_DOWN: begin
                            ent.kind0 = KIND_SWALLOW;
                            if (!in_pressed) begin
                                phase_next = PH_WAIT_SECOND;
                                time_next  = '0;
                            end
                        end
                        PH_WAIT_SECOND: begin
                            ent.kind0 = KIND_SWALLOW;
                            if (in_pressed) begin
                                if (time_cmp <= term_cmp) begin
                                    phase_next = PH_SECOND_DOWN;
                                end else begin
                                    // Late second press: replay the old tap first.
                                    ent.count  = 2'd3;
                                    ent.kind0  = KIND_PRESS;
                                    ent.kind1  = KIND_RELEASE;
                                    ent.kind2  = KIND_SWALLOW;
                                    phase_next = PH_FIRST_DOWN;
                                    time_next  = '0;
                                end
                            end
                        end
                        PH_SECOND_DOWN: begin
                            if (!in_pressed) begin
                                phase_next = PH_IDLE;
                                ent.kind0  = KIND_TOGGLE;
                            end else begin
                                ent.kind0 = KIND_SWALLOW;
                            end
                        end
                        default: begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
            CMD_TICK: begin
                time_next = time_inc;
                if (inc_cmp >= term_cmp) begin
                    if (phase_reg == PH_FIRST_DOWN) begin
                        ent.count  = 2'd1;
                        ent.kind0  = KIND_PRESS;
                        phase_next = PH_PASS_HELD;
                    end else if (phase_reg == PH_WAIT_SECOND) begin
                        ent.count  = 2'd2;
                        ent.kind0  = KIND_PRESS;
                        ent.kind1  = KIND_RELEASE;
                        phase_next = PH_IDLE;
                    end
                end
            end
            default: begin
                // Other key or session reset: flush; second press only on reset.
                if (phase_reg == PH_FIRST_DOWN) begin
                    ent.count  = 2'd1;
                    ent.kind0  = KIND_PRESS;
                    phase_next = PH_PASS_HELD;
                end else if (phase_reg == PH_WAIT_SECOND) begin
                    ent.count  = 2'd2;
                    ent.kind0  = KIND_PRESS;
                    ent.kind1  = KIND_RELEASE;
                    phase_next = PH_IDLE;
                end else if (phase_reg == PH_SECOND_DOWN &&
                             cmd_t'(in_command) == CMD_SESS_RST) begin
                    ent.count  = 2'd3;
                    ent.kind0  = KIND_PRESS;
                    ent.kind1  = KIND_RELEASE;
                    ent.kind2  = KIND_PRESS;
                    phase_next = PH_PASS_HELD;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            time_reg  <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            time_reg  <= time_next;
        end
    end

    // Beats with no results never enter the queue.
    assign push       = accept && (ent.count != 2'd0);
    assign push_entry = ent;

endmodule

[hw/rtl/dtgd_queue.sv]
// Short queue of result groups between the front and back ends.
// Depends on dtgd_pkg.
module dtgd_queue #(
    parameter int DEPTH = dtgd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  dtgd_pkg::entry_t push_entry,
    input  logic             pop,
    output dtgd_pkg::entry_t pop_entry,
    output logic             not_empty,
    output logic             not_full
);
    import dtgd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t         mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  cnt_reg;
    logic           do_push, do_pop;

    assign not_empty = (cnt_reg != '0);
    assign not_full  = (cnt_reg != CW'(DEPTH));
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign pop_entry = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

[hw/rtl/dtgd_back.sv]
// Back end: takes result groups from the queue and sends them one beat at a
// time on the result channel. Depends on dtgd_pkg.
module dtgd_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_not_empty,
    input  dtgd_pkg::entry_t q_entry,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [2:0]       out_kind,
    output logic             out_last
);
    import dtgd_pkg::*;

    entry_t     ent_reg;
    logic [1:0] idx_reg;
    logic       busy_reg;
    logic       beat_done;

    assign out_valid = busy_reg;
    assign out_last  = (2'(idx_reg + 2'd1) == ent_reg.count);
    assign beat_done = busy_reg && out_ready;
    // Load a new group when idle or as the last beat of the current one leaves.
    assign q_pop     = q_not_empty && (!busy_reg || (beat_done && out_last));

    always_comb begin
        case (idx_reg)
            2'd0:    out_kind = ent_reg.kind0;
            2'd1:    out_kind = ent_reg.kind1;
            default: out_kind = ent_reg.kind2;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_pop) ent_reg <= q_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (q_pop) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (beat_done) begin
            if (out_last) begin
                busy_reg <= 1'b0;
                idx_reg  <= '0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

endmodule

[hw/rtl/dtgd_checker.sv]
// Port-level checks of the double-tap gesture detector, bound to the top level.
// Depends on dtgd_pkg.
module dtgd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_result_kind,
    input logic       m_last
);
    import dtgd_pkg::*;

    // Reset empties the result side.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Hold a stalled result beat.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_kind) && $stable(m_last))
        else $error("stalled result beat changed");

    // Drive only defined kinds.
    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_result_kind == KIND_PASS || m_result_kind == KIND_SWALLOW ||
                     m_result_kind == KIND_PRESS || m_result_kind == KIND_RELEASE ||
                     m_result_kind == KIND_TOGGLE))
        else $error("undefined result kind");

    // A toggle is always the only and final result of its beat.
    a_toggle_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == KIND_TOGGLE |-> m_last)
        else $error("toggle not flagged last");

    // A replayed release always follows a replayed press within the same group.
    a_release_after_press: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_result_kind == KIND_PRESS && !m_last
        |=> m_valid && m_result_kind == KIND_RELEASE)
        else $error("replayed press not followed by release");

endmodule

bind double_tap_gesture_detector dtgd_checker u_dtgd_checker (.*);
